// ----- hw/rtl/pidl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidl_pkg
// Types and constants shared by the positional insert/delete list.
// ----------------------------------------------------------------------------
package pidl_pkg;

  localparam int OP_W  = 2;
  localparam int POS_W = 4;
  localparam int CNT_W = 5;
  localparam int DW    = 32;
  localparam int ST_W  = 2;

  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(16);

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_GET    = 2'd1,
    OP_DELETE = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK            = 2'd0,
    ST_FULL          = 2'd1,
    ST_BEYOND_CAP    = 2'd2,
    ST_NOT_BELOW_LEN = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SH_NONE,
    SH_INSERT,
    SH_DELETE
  } shift_t;

  typedef struct packed {
    shift_t           kind;
    logic [CNT_W-1:0] pos;
    logic [CNT_W-1:0] cnt;
  } cmd_t;

endpackage

// ----- hw/rtl/pidl_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidl_if
// Valid/ready channels of the list: operation in, result out, capacity write.
// ----------------------------------------------------------------------------
interface pidl_in_if;
  logic                     valid;
  logic                     ready;
  logic [pidl_pkg::OP_W-1:0]  opcode;
  logic [pidl_pkg::POS_W-1:0] position;
  logic [pidl_pkg::DW-1:0]    data_word;

  modport source (output valid, opcode, position, data_word, input ready);
  modport sink   (input valid, opcode, position, data_word, output ready);
endinterface

interface pidl_out_if;
  logic                     valid;
  logic                     ready;
  logic [pidl_pkg::ST_W-1:0]  status;
  logic [pidl_pkg::DW-1:0]    read_word;
  logic [pidl_pkg::CNT_W-1:0] list_length;

  modport source (output valid, status, read_word, list_length, input ready);
  modport sink   (input valid, status, read_word, list_length, output ready);
endinterface

interface pidl_cfg_if;
  logic                     valid;
  logic                     ready;
  logic [pidl_pkg::CNT_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- hw/rtl/pidl_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidl_cell
// One list entry: holds, loads the new word, or takes a neighbor's word.
// ----------------------------------------------------------------------------
module pidl_cell #(
  parameter int WORD_WIDTH = 32,
  parameter int IDX        = 0
) (
  input  logic                  clk,
  input  pidl_pkg::cmd_t        cmd,
  input  logic [WORD_WIDTH-1:0] new_word,
  input  logic [WORD_WIDTH-1:0] left_word,
  input  logic [WORD_WIDTH-1:0] right_word,
  output logic [WORD_WIDTH-1:0] word_r
);
  import pidl_pkg::*;

  // count never exceeds 31, so cells from index 31 up never hold an entry
  localparam bit               LIVE = (IDX < 31);
  localparam logic [CNT_W-1:0] IDX5 = CNT_W'(LIVE ? IDX : 0);

  logic [WORD_WIDTH-1:0] word_nxt;

  always_comb begin
    word_nxt = word_r;
    unique case (cmd.kind)
      SH_INSERT: begin
        if (LIVE && IDX5 == cmd.pos) begin
          word_nxt = new_word;
        end else if (LIVE && IDX5 > cmd.pos && IDX5 <= cmd.cnt) begin
          word_nxt = left_word;
        end
      end
      SH_DELETE: begin
        if (LIVE && IDX5 >= cmd.pos && (IDX5 + CNT_W'(1)) < cmd.cnt) begin
          word_nxt = right_word;
        end
      end
      default: word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

endmodule

// ----- hw/rtl/pidl_chain.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidl_chain
// Row of entry cells with neighbor links and a read tap at the position.
// ----------------------------------------------------------------------------
module pidl_chain #(
  parameter int DEPTH      = 16,
  parameter int WORD_WIDTH = 32
) (
  input  logic                         clk,
  input  pidl_pkg::cmd_t               cmd,
  input  logic [WORD_WIDTH-1:0]        new_word,
  input  logic [pidl_pkg::POS_W-1:0]   rd_pos,
  output logic [WORD_WIDTH-1:0]        rd_word
);
  import pidl_pkg::*;

  localparam int TAPS = 1 << POS_W;

  logic [WORD_WIDTH-1:0] word_q [DEPTH];
  logic [WORD_WIDTH-1:0] left_q [DEPTH];
  logic [WORD_WIDTH-1:0] right_q[DEPTH];
  logic [WORD_WIDTH-1:0] tap    [TAPS];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_q[i] = '0;
    end else begin : g_mid_l
      assign left_q[i] = word_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_q[i] = '0;
    end else begin : g_mid_r
      assign right_q[i] = word_q[i+1];
    end

    pidl_cell #(
      .WORD_WIDTH (WORD_WIDTH),
      .IDX        (i)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .new_word   (new_word),
      .left_word  (left_q[i]),
      .right_word (right_q[i]),
      .word_r     (word_q[i])
    );
  end

  for (genvar t = 0; t < TAPS; t++) begin : g_tap
    if (t < DEPTH) begin : g_on
      assign tap[t] = word_q[t];
    end else begin : g_off
      assign tap[t] = '0;
    end
  end

  assign rd_word = tap[rd_pos];

endmodule

// ----- hw/rtl/positional_insert_delete_list.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_insert_delete_list
// Ordered word list with insert, get, delete and clear at a list position.
// ----------------------------------------------------------------------------
// Every transaction on in_ch gives exactly one result transaction on out_ch.
// At the accepting edge the row of entry cells shifts the entries from the
// position on up or down together, and the result sits in an output register
// the following cycle. A new operation is accepted whenever that register is
// empty or being drained, so one operation per cycle is sustained while out_ch
// is ready. Capacity is written on cfg_ch (ready whenever out of reset) only
// while the list is idle; the user must ensure this, the block does not.
// Capacity used is min(written, DEPTH, 31); in_ch, cfg_ch never ready in reset.
// ----------------------------------------------------------------------------
module positional_insert_delete_list #(
  parameter int DEPTH      = 16,
  parameter int WORD_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  pidl_in_if.sink    in_ch,
  pidl_out_if.source out_ch,
  pidl_cfg_if.sink   cfg_ch
);
  import pidl_pkg::*;

  localparam int               CAP_LIM_I = (DEPTH < 31) ? DEPTH : 31;
  localparam logic [CNT_W-1:0] CAP_LIM   = CNT_W'(CAP_LIM_I);

  logic [CNT_W-1:0] capacity_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r;
  status_t          status_r, status_nxt;
  logic [DW-1:0]    read_word_r, read_word_nxt;

  logic             accept;
  logic [CNT_W-1:0] eff_cap;
  logic [CNT_W-1:0] pos5;
  opcode_t          op;
  cmd_t             cmd;
  logic             shift_en;
  shift_t           shift_kind;
  logic [CNT_W-1:0] shift_pos;
  logic             rd_en;
  logic [63:0]      wr64;
  logic [63:0]      rd64;
  logic [WORD_WIDTH-1:0] wr_word;
  logic [WORD_WIDTH-1:0] rd_word;

  assign in_ch.ready  = rst_n && (!out_valid_r || out_ch.ready);
  assign cfg_ch.ready = rst_n;
  assign accept       = in_ch.valid && in_ch.ready;

  assign eff_cap = (capacity_r > CAP_LIM) ? CAP_LIM : capacity_r;
  assign pos5    = {1'b0, in_ch.position};
  assign op      = opcode_t'(in_ch.opcode);

  always_comb begin
    status_nxt = ST_OK;
    count_nxt  = count_r;
    shift_kind = SH_NONE;
    shift_pos  = pos5;
    rd_en      = 1'b0;
    unique case (op)
      OP_INSERT: begin
        if (count_r >= eff_cap) begin
          status_nxt = ST_FULL;
        end else if (pos5 >= eff_cap) begin
          status_nxt = ST_BEYOND_CAP;
        end else begin
          shift_kind = SH_INSERT;
          shift_pos  = (pos5 > count_r) ? count_r : pos5;
          count_nxt  = count_r + CNT_W'(1);
        end
      end
      OP_GET: begin
        if (pos5 >= count_r) begin
          status_nxt = ST_NOT_BELOW_LEN;
        end else begin
          rd_en = 1'b1;
        end
      end
      OP_DELETE: begin
        if (pos5 >= count_r) begin
          status_nxt = ST_NOT_BELOW_LEN;
        end else begin
          rd_en      = 1'b1;
          shift_kind = SH_DELETE;
          count_nxt  = count_r - CNT_W'(1);
        end
      end
      OP_CLEAR: begin
        count_nxt = '0;
      end
      default: status_nxt = ST_OK;
    endcase
  end

  assign shift_en = accept && (shift_kind != SH_NONE);
  assign cmd.kind = shift_en ? shift_kind : SH_NONE;
  assign cmd.pos  = shift_pos;
  assign cmd.cnt  = count_r;

  assign wr64    = 64'(in_ch.data_word);
  assign wr_word = wr64[WORD_WIDTH-1:0];

  pidl_chain #(
    .DEPTH      (DEPTH),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_chain (
    .clk      (clk),
    .cmd      (cmd),
    .new_word (wr_word),
    .rd_pos   (in_ch.position),
    .rd_word  (rd_word)
  );

  assign rd64          = 64'(rd_word);
  assign read_word_nxt = rd_en ? rd64[DW-1:0] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r  <= CAP_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        capacity_r <= cfg_ch.data;
      end
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r    <= status_nxt;
      read_word_r <= read_word_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = status_r;
  assign out_ch.read_word   = read_word_r;
  assign out_ch.list_length = count_r;

endmodule
